// ===== rtl/dkh_pkg.sv =====
// Shared constants, codes and control types for the k-mer histogram unit.
package dkh_pkg;

    localparam int K_MAX_DEF       = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int K_MIN           = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_DEPTH       = 4;

    localparam logic [3:0] K_SIZE_RESET = 4'd3;

    // Opcodes of an input transfer
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Count table selection
    localparam logic [1:0] SEL_K  = 2'd0;
    localparam logic [1:0] SEL_K1 = 2'd1;
    localparam logic [1:0] SEL_K2 = 2'd2;

    // ASCII base characters and their codes
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_C = 8'h43;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_T = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_C = 2'd3;

    // Classified command handed from front to back
    typedef struct packed {
        logic       is_read;
        logic       bad;
        logic [1:0] sel;
        logic       inc_k;
        logic       inc_k1;
        logic       inc_k2;
    } dkh_ctrl_t;

endpackage

// ===== rtl/dkh_in_if.sv =====
// Input channel interface: one command per transfer.
interface dkh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  base_char;
    logic [1:0]  table_select;
    logic [15:0] read_index;

    modport source (output valid, output opcode, output base_char, output table_select,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input base_char, input table_select,
                    input read_index, output ready);
endinterface

// ===== rtl/dkh_out_if.sv =====
// Result channel interface: one result per accepted command.
interface dkh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] count_value;
    logic        bad_base;

    modport source (output valid, output count_value, output bad_base, input ready);
    modport sink   (input valid, input count_value, input bad_base, output ready);
endinterface

// ===== rtl/dkh_cmd_queue.sv =====
// Small register FIFO carrying classified commands from front to back.
module dkh_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dkh_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dkh_front.sv =====
// Front end: accepts commands, holds k and the base window, classifies each command.
module dkh_front #(
    parameter int K_MAX = dkh_pkg::K_MAX_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [3:0]               cfg_wr_data,
    dkh_in_if.sink                   in_ch,
    input  logic                     q_ready,
    input  logic                     clr_busy,
    output logic                     push_valid,
    output dkh_pkg::dkh_ctrl_t       ctrl,
    output logic [2*K_MAX-1:0]       addr_k,
    output logic [2*(K_MAX-1)-1:0]   addr_k1,
    output logic [2*(K_MAX-2)-1:0]   addr_k2
);

    localparam int AK   = 2 * K_MAX;
    localparam int AK1  = 2 * (K_MAX - 1);
    localparam int AK2  = 2 * (K_MAX - 2);
    localparam int SW   = $clog2(K_MAX + 1);
    localparam int CMPW = (SW > 4) ? SW : 4;

    logic [3:0]      k_size_reg;
    logic [AK-1:0]   window_reg, window_next;
    logic [SW-1:0]   seen_reg, seen_next;

    logic            fire;
    logic            code_ok;
    logic [1:0]      code;
    logic [CMPW-1:0] k_raw, k_eff;
    logic [CMPW-1:0] seen_ext, seen_inc;
    logic [AK-1:0]   window_shift;
    logic [AK-1:0]   mask_k, mask_k1, mask_k2;
    logic [AK+15:0]  idx_ext;

    assign in_ch.ready = q_ready && !clr_busy;
    assign fire        = in_ch.valid && in_ch.ready;
    assign push_valid  = fire;

    // Clamp k into the supported range
    assign k_raw = CMPW'(k_size_reg);
    always_comb
    begin
        k_eff = k_raw;
        if (k_raw < CMPW'(dkh_pkg::K_MIN))
        begin
            k_eff = CMPW'(dkh_pkg::K_MIN);
        end
        else if (k_raw > CMPW'(K_MAX))
        begin
            k_eff = CMPW'(K_MAX);
        end
    end

    always_comb
    begin
        code_ok = 1'b1;
        case (in_ch.base_char)
            dkh_pkg::CH_A: code = dkh_pkg::CODE_A;
            dkh_pkg::CH_T: code = dkh_pkg::CODE_T;
            dkh_pkg::CH_G: code = dkh_pkg::CODE_G;
            dkh_pkg::CH_C: code = dkh_pkg::CODE_C;
            default:
            begin
                code    = dkh_pkg::CODE_A;
                code_ok = 1'b0;
            end
        endcase
    end

    assign window_shift = {window_reg[AK-3:0], code};
    assign seen_ext     = CMPW'(seen_reg);
    assign seen_inc     = (seen_ext < CMPW'(K_MAX)) ? seen_ext + 1'b1 : seen_ext;
    assign idx_ext      = {{AK{1'b0}}, in_ch.read_index};

    // Digit masks for the three substring lengths
    always_comb
    begin
        for (int d = 0; d < K_MAX; d++)
        begin
            mask_k[2*d +: 2]  = {2{CMPW'(d) < k_eff}};
            mask_k1[2*d +: 2] = {2{CMPW'(d + 1) < k_eff}};
            mask_k2[2*d +: 2] = {2{CMPW'(d + 2) < k_eff}};
        end
    end

    always_comb
    begin
        ctrl        = '0;
        addr_k      = '0;
        addr_k1     = '0;
        addr_k2     = '0;
        window_next = window_reg;
        seen_next   = seen_reg;
        case (in_ch.opcode)
            dkh_pkg::OP_PUSH:
            begin
                if (code_ok)
                begin
                    window_next = window_shift;
                    seen_next   = SW'(seen_inc);
                    ctrl.inc_k  = (seen_inc >= k_eff);
                    ctrl.inc_k1 = ((seen_inc + 1'b1) >= k_eff);
                    ctrl.inc_k2 = ((seen_inc + 2'd2) >= k_eff);
                    addr_k      = window_shift & mask_k;
                    addr_k1     = window_shift[AK1-1:0] & mask_k1[AK1-1:0];
                    addr_k2     = window_shift[AK2-1:0] & mask_k2[AK2-1:0];
                end
                else
                begin
                    ctrl.bad    = 1'b1;
                    window_next = '0;
                    seen_next   = '0;
                end
            end
            dkh_pkg::OP_READ:
            begin
                ctrl.is_read = 1'b1;
                ctrl.sel     = in_ch.table_select;
                addr_k       = idx_ext[AK-1:0];
                addr_k1      = idx_ext[AK1-1:0];
                addr_k2      = idx_ext[AK2-1:0];
            end
            dkh_pkg::OP_RESTART:
            begin
                window_next = '0;
                seen_next   = '0;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_size_reg <= dkh_pkg::K_SIZE_RESET;
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                k_size_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

// ===== rtl/dkh_back.sv =====
// Back end: three count memories with read-modify-write, forwarding and a result FIFO.
module dkh_back #(
    parameter int K_MAX       = dkh_pkg::K_MAX_DEF,
    parameter int COUNT_WIDTH = dkh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    output logic                     head_pop,
    input  dkh_pkg::dkh_ctrl_t       head_ctrl,
    input  logic [2*K_MAX-1:0]       head_addr_k,
    input  logic [2*(K_MAX-1)-1:0]   head_addr_k1,
    input  logic [2*(K_MAX-2)-1:0]   head_addr_k2,
    output logic                     clr_busy,
    dkh_out_if.source                out_ch
);

    localparam int AK   = 2 * K_MAX;
    localparam int AK1  = 2 * (K_MAX - 1);
    localparam int AK2  = 2 * (K_MAX - 2);
    localparam int CW   = COUNT_WIDTH;
    localparam int OD   = dkh_pkg::OUT_DEPTH;
    localparam int OPW  = (OD > 1) ? $clog2(OD) : 1;
    localparam int OCW  = $clog2(OD + 2);

    logic [CW-1:0] kmer_mem [1 << AK];
    logic [CW-1:0] km1_mem  [1 << AK1];
    logic [CW-1:0] km2_mem  [1 << AK2];

    // Clearing pass
    logic          clr_busy_reg;
    logic [AK-1:0] clr_cnt_reg;

    // Read data and stage one
    logic [CW-1:0]       rd_k_reg, rd_k1_reg, rd_k2_reg;
    logic                s1_valid_reg;
    dkh_pkg::dkh_ctrl_t  s1_ctrl_reg;
    logic [AK-1:0]       s1_addr_k_reg;
    logic [AK1-1:0]      s1_addr_k1_reg;
    logic [AK2-1:0]      s1_addr_k2_reg;

    // Last write of each memory, for forwarding
    logic           fw_k_vld_reg, fw_k1_vld_reg, fw_k2_vld_reg;
    logic [AK-1:0]  fw_k_addr_reg;
    logic [AK1-1:0] fw_k1_addr_reg;
    logic [AK2-1:0] fw_k2_addr_reg;
    logic [CW-1:0]  fw_k_data_reg, fw_k1_data_reg, fw_k2_data_reg;

    logic [CW-1:0]  cur_k, cur_k1, cur_k2;
    logic [CW-1:0]  inc_k_val, inc_k1_val, inc_k2_val;
    logic           we_k, we_k1, we_k2;
    logic [AK-1:0]  wa_k;
    logic [AK1-1:0] wa_k1;
    logic [AK2-1:0] wa_k2;
    logic [CW-1:0]  wd_k, wd_k1, wd_k2;
    logic [CW-1:0]  sel_count;
    logic [CW+31:0] sel_ext;

    // Result FIFO
    logic [31:0]    res_cnt_reg [OD];
    logic           res_bad_reg [OD];
    logic [OPW-1:0] res_wr_reg, res_rd_reg;
    logic [OCW-1:0] res_occ_reg;
    logic           res_pop;

    assign clr_busy = clr_busy_reg;

    // Issue only when the result FIFO has room for everything in flight
    assign head_pop = head_valid && !clr_busy_reg &&
                      ((res_occ_reg + OCW'(s1_valid_reg)) < OCW'(OD));

    // Forward the write that landed at the same edge as this read
    assign cur_k  = (fw_k_vld_reg && fw_k_addr_reg == s1_addr_k_reg) ? fw_k_data_reg : rd_k_reg;
    assign cur_k1 = (fw_k1_vld_reg && fw_k1_addr_reg == s1_addr_k1_reg) ? fw_k1_data_reg
                                                                         : rd_k1_reg;
    assign cur_k2 = (fw_k2_vld_reg && fw_k2_addr_reg == s1_addr_k2_reg) ? fw_k2_data_reg
                                                                         : rd_k2_reg;

    // Saturating increments
    assign inc_k_val  = (cur_k == '1) ? cur_k : cur_k + 1'b1;
    assign inc_k1_val = (cur_k1 == '1) ? cur_k1 : cur_k1 + 1'b1;
    assign inc_k2_val = (cur_k2 == '1) ? cur_k2 : cur_k2 + 1'b1;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            we_k  = 1'b1;
            we_k1 = 1'b1;
            we_k2 = 1'b1;
            wa_k  = clr_cnt_reg;
            wa_k1 = clr_cnt_reg[AK1-1:0];
            wa_k2 = clr_cnt_reg[AK2-1:0];
            wd_k  = '0;
            wd_k1 = '0;
            wd_k2 = '0;
        end
        else
        begin
            we_k  = s1_valid_reg && s1_ctrl_reg.inc_k;
            we_k1 = s1_valid_reg && s1_ctrl_reg.inc_k1;
            we_k2 = s1_valid_reg && s1_ctrl_reg.inc_k2;
            wa_k  = s1_addr_k_reg;
            wa_k1 = s1_addr_k1_reg;
            wa_k2 = s1_addr_k2_reg;
            wd_k  = inc_k_val;
            wd_k1 = inc_k1_val;
            wd_k2 = inc_k2_val;
        end
    end

    always_comb
    begin
        sel_count = '0;
        if (s1_ctrl_reg.is_read)
        begin
            case (s1_ctrl_reg.sel)
                dkh_pkg::SEL_K:  sel_count = cur_k;
                dkh_pkg::SEL_K1: sel_count = cur_k1;
                dkh_pkg::SEL_K2: sel_count = cur_k2;
                default:         sel_count = '0;
            endcase
        end
    end

    assign sel_ext = {32'd0, sel_count};

    // Memories: registered read at issue, write from stage one or the clearing pass
    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            rd_k_reg <= kmer_mem[head_addr_k];
        end
        if (we_k)
        begin
            kmer_mem[wa_k] <= wd_k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            rd_k1_reg <= km1_mem[head_addr_k1];
        end
        if (we_k1)
        begin
            km1_mem[wa_k1] <= wd_k1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            rd_k2_reg <= km2_mem[head_addr_k2];
        end
        if (we_k2)
        begin
            km2_mem[wa_k2] <= wd_k2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fw_k_vld_reg  <= 1'b0;
            fw_k1_vld_reg <= 1'b0;
            fw_k2_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= head_pop;
            fw_k_vld_reg  <= we_k;
            fw_k1_vld_reg <= we_k1;
            fw_k2_vld_reg <= we_k2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            s1_ctrl_reg    <= head_ctrl;
            s1_addr_k_reg  <= head_addr_k;
            s1_addr_k1_reg <= head_addr_k1;
            s1_addr_k2_reg <= head_addr_k2;
        end
        fw_k_addr_reg  <= wa_k;
        fw_k1_addr_reg <= wa_k1;
        fw_k2_addr_reg <= wa_k2;
        fw_k_data_reg  <= wd_k;
        fw_k1_data_reg <= wd_k1;
        fw_k2_data_reg <= wd_k2;
    end

    // Result FIFO towards the output channel
    assign out_ch.valid       = (res_occ_reg != '0);
    assign out_ch.count_value = res_cnt_reg[res_rd_reg];
    assign out_ch.bad_base    = res_bad_reg[res_rd_reg];
    assign res_pop            = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_occ_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                res_wr_reg <= (res_wr_reg == OPW'(OD - 1)) ? '0 : res_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_reg <= (res_rd_reg == OPW'(OD - 1)) ? '0 : res_rd_reg + 1'b1;
            end
            if (s1_valid_reg && !res_pop)
            begin
                res_occ_reg <= res_occ_reg + 1'b1;
            end
            else if (res_pop && !s1_valid_reg)
            begin
                res_occ_reg <= res_occ_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            res_cnt_reg[res_wr_reg] <= sel_ext[31:0];
            res_bad_reg[res_wr_reg] <= s1_ctrl_reg.bad;
        end
    end

endmodule

// ===== rtl/dna_kmer_histogram_unit.sv =====
// Top level of the streaming DNA k-mer histogram unit.
//
// Usage
//   in_ch carries one command per transfer: push a base (A, T, G, C), read
//   one count from the k, k-1 or k-2 table, or restart the base window.
//   out_ch returns exactly one result per command, in command order:
//   count_value for reads, bad_base for a rejected character, zeros else.
//   cfg_wr_en / cfg_wr_data write k_size; write it only while no command
//   is outstanding.
// Timing
//   One command per cycle sustained while out_ch keeps accepting results. A
//   result passes from its input transfer through the command queue and the
//   registered memory read to the read-modify-write stage, which loads the
//   result FIFO that drives out_ch. Each count memory takes one read and one
//   write per cycle, with the last write forwarded.
// Reset and stalls
//   After reset a clearing pass zeroes the count memories, 4^K_MAX addresses
//   (65536 at the default), with in_ch.ready held low. k_size returns to 3.
//   When out_ch stalls the result FIFO fills, issue from the command queue
//   halts and then in_ch.ready drops; no result is lost.
module dna_kmer_histogram_unit #(
    parameter int K_MAX       = dkh_pkg::K_MAX_DEF,
    parameter int COUNT_WIDTH = dkh_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    dkh_in_if.sink      in_ch,
    dkh_out_if.source   out_ch
);

    localparam int AK    = 2 * K_MAX;
    localparam int AK1   = 2 * (K_MAX - 1);
    localparam int AK2   = 2 * (K_MAX - 2);
    localparam int CMD_W = $bits(dkh_pkg::dkh_ctrl_t) + AK + AK1 + AK2;

    // Front side of the command queue
    logic               f_push_valid;
    logic               q_push_ready;
    dkh_pkg::dkh_ctrl_t f_ctrl;
    logic [AK-1:0]      f_addr_k;
    logic [AK1-1:0]     f_addr_k1;
    logic [AK2-1:0]     f_addr_k2;
    logic [CMD_W-1:0]   q_push_data;

    // Back side of the command queue
    logic               q_pop_valid;
    logic               b_pop;
    logic [CMD_W-1:0]   q_pop_data;
    dkh_pkg::dkh_ctrl_t h_ctrl;
    logic [AK-1:0]      h_addr_k;
    logic [AK1-1:0]     h_addr_k1;
    logic [AK2-1:0]     h_addr_k2;

    logic               clr_busy;

    // Classify each transfer and advance the window
    dkh_front #(
        .K_MAX (K_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_ready     (q_push_ready),
        .clr_busy    (clr_busy),
        .push_valid  (f_push_valid),
        .ctrl        (f_ctrl),
        .addr_k      (f_addr_k),
        .addr_k1     (f_addr_k1),
        .addr_k2     (f_addr_k2)
    );

    assign q_push_data = {f_ctrl, f_addr_k, f_addr_k1, f_addr_k2};

    // Decouple classification from the memory pipeline
    dkh_cmd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (dkh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (b_pop),
        .pop_data   (q_pop_data)
    );

    assign {h_ctrl, h_addr_k, h_addr_k1, h_addr_k2} = q_pop_data;

    // Count, read back and deliver results
    dkh_back #(
        .K_MAX       (K_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_pop_valid),
        .head_pop     (b_pop),
        .head_ctrl    (h_ctrl),
        .head_addr_k  (h_addr_k),
        .head_addr_k1 (h_addr_k1),
        .head_addr_k2 (h_addr_k2),
        .clr_busy     (clr_busy),
        .out_ch       (out_ch)
    );

endmodule
